// ===== design/pbfl_pkg.sv =====
package pbfl_pkg;

  localparam int PBFL_DEPTH = 256;
  localparam int FUNC_W     = 3;
  localparam int IDX_W      = 8;
  localparam int STAT_W     = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC      = 3'd0,
    FN_POST_AUDIO = 3'd1,
    FN_POST_VIDEO = 3'd2,
    FN_TAKE_AUDIO = 3'd3,
    FN_TAKE_VIDEO = 3'd4,
    FN_FREE       = 3'd5
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // where the result index of an item in flight comes from
  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_FREE  = 2'd1,
    SRC_READY = 2'd2,
    SRC_INIT  = 2'd3
  } src_t;

  // ready memory half select
  localparam logic SEL_AUDIO = 1'b0;
  localparam logic SEL_VIDEO = 1'b1;

endpackage

// ===== design/pbfl_if.sv =====
interface pbfl_in_if
  import pbfl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0]  buf_index;

  modport source (output valid, output func, output buf_index, input ready);
  modport sink   (input valid, input func, input buf_index, output ready);
endinterface

interface pbfl_out_if
  import pbfl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  result_index;
  logic [STAT_W-1:0] status;

  modport source (output valid, output result_index, output status, input ready);
  modport sink   (input valid, input result_index, input status, output ready);
endinterface

// ===== design/pbfl_ram.sv =====
module pbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/packet_buffer_free_list_manager.sv =====
// An accepted item is held in stage 1 while its memory read is in flight,
// then in the output register. Throughput: one item per cycle while the
// output is taken; ring pointers and counts are registers, and each item
// makes at most one access to one of the two memories.
// Reset (rst_n, synchronous): pointers and counts cleared, free count DEPTH.
// The free ring reads as entry i = i until its write pointer has covered
// the entry (fill mark), so no clearing pass is needed after reset.
module packet_buffer_free_list_manager
  import pbfl_pkg::*;
#(
  parameter int DEPTH = PBFL_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  pbfl_in_if.sink      in_ch,
  pbfl_out_if.source   out_ch
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // ring pointer width
  localparam int CW = $clog2(DEPTH + 1);                 // occupancy width
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;         // pointer as index

  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] n;
    n = (p == PTR_LAST) ? '0 : p + 1'b1;
    return n;
  endfunction

  // ------------------------------------------------------------------
  // Ring control state
  // ------------------------------------------------------------------
  logic [AW-1:0] free_rd_r, free_rd_nxt, free_wr_r, free_wr_nxt;
  logic [AW-1:0] aud_rd_r,  aud_rd_nxt,  aud_wr_r,  aud_wr_nxt;
  logic [AW-1:0] vid_rd_r,  vid_rd_nxt,  vid_wr_r,  vid_wr_nxt;
  logic [CW-1:0] free_cnt_r, free_cnt_nxt;
  logic [CW-1:0] aud_cnt_r,  aud_cnt_nxt;
  logic [CW-1:0] vid_cnt_r,  vid_cnt_nxt;
  // set once the free write pointer has wrapped: every free entry written
  logic          free_wrap_r, free_wrap_nxt;

  // stage 1: item whose memory read is in flight
  logic              p1_v_r, p1_v_nxt;
  status_t           p1_stat_r, p1_stat_nxt;
  src_t              p1_src_r, p1_src_nxt;
  logic [IDX_W-1:0]  p1_init_r, p1_init_nxt;

  // output register
  logic              out_v_r, out_v_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  status_t           out_stat_r, out_stat_nxt;

  // memory ports
  logic              free_we, free_re;
  logic [AW-1:0]     free_waddr, free_raddr;
  logic [IDX_W-1:0]  free_rdata;
  logic              rdy_we, rdy_re;
  logic [AW:0]       rdy_waddr, rdy_raddr;
  logic [IDX_W-1:0]  rdy_rdata;

  logic              acc;
  logic              p1_adv;
  logic [XW-1:0]     rd_ext;
  logic [IDX_W-1:0]  p1_result;

  // stage 1 moves on when the output register is empty or being taken
  assign p1_adv      = !out_v_r || out_ch.ready;
  assign in_ch.ready = !p1_v_r || p1_adv;
  assign acc         = in_ch.valid && in_ch.ready;
  assign rd_ext      = XW'(free_rd_r);

  // ------------------------------------------------------------------
  // Decode and ring update
  // ------------------------------------------------------------------
  always_comb begin
    free_rd_nxt   = free_rd_r;
    free_wr_nxt   = free_wr_r;
    aud_rd_nxt    = aud_rd_r;
    aud_wr_nxt    = aud_wr_r;
    vid_rd_nxt    = vid_rd_r;
    vid_wr_nxt    = vid_wr_r;
    free_cnt_nxt  = free_cnt_r;
    aud_cnt_nxt   = aud_cnt_r;
    vid_cnt_nxt   = vid_cnt_r;
    free_wrap_nxt = free_wrap_r;

    free_we    = 1'b0;
    free_re    = 1'b0;
    free_waddr = free_wr_r;
    free_raddr = free_rd_r;
    rdy_we     = 1'b0;
    rdy_re     = 1'b0;
    rdy_waddr  = {SEL_AUDIO, aud_wr_r};
    rdy_raddr  = {SEL_AUDIO, aud_rd_r};

    p1_stat_nxt = ST_DONE;
    p1_src_nxt  = SRC_NONE;
    // unwritten free entry i holds i
    p1_init_nxt = rd_ext[IDX_W-1:0];

    if (acc) begin
      unique case (func_t'(in_ch.func))
        FN_ALLOC: begin
          if (free_cnt_r == '0) begin
            p1_stat_nxt = ST_EMPTY;
          end else begin
            if (free_wrap_r || (free_rd_r < free_wr_r)) begin
              free_re    = 1'b1;
              p1_src_nxt = SRC_FREE;
            end else begin
              p1_src_nxt = SRC_INIT;
            end
            free_rd_nxt  = ptr_inc(free_rd_r);
            free_cnt_nxt = free_cnt_r - 1'b1;
          end
        end
        FN_POST_AUDIO: begin
          if (aud_cnt_r == CNT_FULL) begin
            p1_stat_nxt = ST_FULL;
          end else begin
            rdy_we      = 1'b1;
            rdy_waddr   = {SEL_AUDIO, aud_wr_r};
            aud_wr_nxt  = ptr_inc(aud_wr_r);
            aud_cnt_nxt = aud_cnt_r + 1'b1;
          end
        end
        FN_POST_VIDEO: begin
          if (vid_cnt_r == CNT_FULL) begin
            p1_stat_nxt = ST_FULL;
          end else begin
            rdy_we      = 1'b1;
            rdy_waddr   = {SEL_VIDEO, vid_wr_r};
            vid_wr_nxt  = ptr_inc(vid_wr_r);
            vid_cnt_nxt = vid_cnt_r + 1'b1;
          end
        end
        FN_TAKE_AUDIO: begin
          if (aud_cnt_r == '0) begin
            p1_stat_nxt = ST_EMPTY;
          end else begin
            rdy_re      = 1'b1;
            rdy_raddr   = {SEL_AUDIO, aud_rd_r};
            p1_src_nxt  = SRC_READY;
            aud_rd_nxt  = ptr_inc(aud_rd_r);
            aud_cnt_nxt = aud_cnt_r - 1'b1;
          end
        end
        FN_TAKE_VIDEO: begin
          if (vid_cnt_r == '0) begin
            p1_stat_nxt = ST_EMPTY;
          end else begin
            rdy_re      = 1'b1;
            rdy_raddr   = {SEL_VIDEO, vid_rd_r};
            p1_src_nxt  = SRC_READY;
            vid_rd_nxt  = ptr_inc(vid_rd_r);
            vid_cnt_nxt = vid_cnt_r - 1'b1;
          end
        end
        FN_FREE: begin
          if (free_cnt_r == CNT_FULL) begin
            p1_stat_nxt = ST_FULL;
          end else begin
            free_we      = 1'b1;
            free_waddr   = free_wr_r;
            free_wr_nxt  = ptr_inc(free_wr_r);
            free_cnt_nxt = free_cnt_r + 1'b1;
            if (free_wr_r == PTR_LAST) begin
              free_wrap_nxt = 1'b1;
            end
          end
        end
        default: begin
          // unused codes: no change, done with index zero
        end
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Pipeline control
  // ------------------------------------------------------------------
  always_comb begin
    if (acc) begin
      p1_v_nxt = 1'b1;
    end else if (p1_adv) begin
      p1_v_nxt = 1'b0;
    end else begin
      p1_v_nxt = p1_v_r;
    end
  end

  always_comb begin
    unique case (p1_src_r)
      SRC_FREE:  p1_result = free_rdata;
      SRC_READY: p1_result = rdy_rdata;
      SRC_INIT:  p1_result = p1_init_r;
      default:   p1_result = '0;
    endcase
  end

  always_comb begin
    out_v_nxt    = out_v_r;
    out_idx_nxt  = out_idx_r;
    out_stat_nxt = out_stat_r;
    if (p1_v_r && p1_adv) begin
      out_v_nxt    = 1'b1;
      out_idx_nxt  = p1_result;
      out_stat_nxt = p1_stat_r;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_rd_r   <= '0;
      free_wr_r   <= '0;
      aud_rd_r    <= '0;
      aud_wr_r    <= '0;
      vid_rd_r    <= '0;
      vid_wr_r    <= '0;
      free_cnt_r  <= CNT_FULL;
      aud_cnt_r   <= '0;
      vid_cnt_r   <= '0;
      free_wrap_r <= 1'b0;
      p1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      free_rd_r   <= free_rd_nxt;
      free_wr_r   <= free_wr_nxt;
      aud_rd_r    <= aud_rd_nxt;
      aud_wr_r    <= aud_wr_nxt;
      vid_rd_r    <= vid_rd_nxt;
      vid_wr_r    <= vid_wr_nxt;
      free_cnt_r  <= free_cnt_nxt;
      aud_cnt_r   <= aud_cnt_nxt;
      vid_cnt_r   <= vid_cnt_nxt;
      free_wrap_r <= free_wrap_nxt;
      p1_v_r      <= p1_v_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (acc) begin
      p1_stat_r <= p1_stat_nxt;
      p1_src_r  <= p1_src_nxt;
      p1_init_r <= p1_init_nxt;
    end
    out_idx_r  <= out_idx_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // ------------------------------------------------------------------
  // Memories: free ring, and audio/video rings sharing one RAM
  // ------------------------------------------------------------------
  pbfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (2**AW)
  ) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (in_ch.buf_index),
    .re    (free_re),
    .raddr (free_raddr),
    .rdata (free_rdata)
  );

  pbfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (2**(AW + 1))
  ) u_ready_ram (
    .clk   (clk),
    .we    (rdy_we),
    .waddr (rdy_waddr),
    .wdata (in_ch.buf_index),
    .re    (rdy_re),
    .raddr (rdy_raddr),
    .rdata (rdy_rdata)
  );

  assign out_ch.valid        = out_v_r;
  assign out_ch.result_index = out_idx_r;
  assign out_ch.status       = out_stat_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (free_cnt_r <= CNT_FULL) && (aud_cnt_r <= CNT_FULL) && (vid_cnt_r <= CNT_FULL))
    else $error("ring occupancy above DEPTH");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (free_rd_r <= PTR_LAST) && (free_wr_r <= PTR_LAST) && (aud_rd_r <= PTR_LAST) &&
    (aud_wr_r <= PTR_LAST) && (vid_rd_r <= PTR_LAST) && (vid_wr_r <= PTR_LAST))
    else $error("ring pointer out of range");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_v_r && !p1_adv) |-> !in_ch.ready)
    else $error("item accepted while stage 1 is stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_stat_r != ST_DONE)) |-> (out_idx_r == '0))
    else $error("non-zero index on a failed item");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({free_we, free_re, rdy_we, rdy_re}) <= 1)
    else $error("more than one memory access for one item");
`endif

endmodule
